/* design/iolsp_pkg.sv */
// Package: constants, widths and state codes for the I/O latency statistics block.
`timescale 1ns / 1ps
package iolsp_pkg;
  // SAMPLE_DEPTH must be a power of two; store address is {class, index}.
  localparam int SAMPLE_DEPTH = 1024;
  localparam int NUM_CLASSES  = 3;
  localparam int CLS_W        = 2;
  localparam int IDX_W        = $clog2(SAMPLE_DEPTH);
  localparam int FILL_W       = $clog2(SAMPLE_DEPTH + 1);
  localparam int MEM_AW       = CLS_W + IDX_W;
  localparam int MEM_DEPTH    = NUM_CLASSES * SAMPLE_DEPTH;
  localparam int LAT_W        = 32;
  localparam int BIT_W        = $clog2(LAT_W);
  localparam int PCT_W        = 16;
  localparam int DVD_W        = IDX_W + PCT_W;
  localparam int CNT_W        = 48;
  localparam int SUM_W        = 64;
  localparam int MIN_W        = 64;

  localparam logic [CLS_W-1:0] NUM_CLASSES_C = CLS_W'(NUM_CLASSES);
  localparam logic [FILL_W-1:0] FILL_MAX    = FILL_W'(SAMPLE_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_MAX    = '1;

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [0:0] ADDR_RECORD_ENABLE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SCAN,
    ST_OUT
  } state_t;
endpackage

/* design/iolsp_div.sv */
// Restoring divider, one quotient bit per cycle, for the percentile rank.
`timescale 1ns / 1ps
module iolsp_div
  import iolsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [PCT_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam logic [$clog2(DVD_W)-1:0] LAST_STEP = $clog2(DVD_W)'(DVD_W - 1);

  logic                     busy;
  logic [$clog2(DVD_W)-1:0] step;
  logic [DVD_W-1:0]         dq;
  logic [PCT_W-1:0]         rem;
  logic [PCT_W-1:0]         dsr;
  logic [PCT_W:0]           trial;
  logic                     fits;

  assign trial    = {rem, dq[DVD_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= LAST_STEP;
        dq   <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? PCT_W'(trial - {1'b0, dsr}) : trial[PCT_W-1:0];
        dq  <= {dq[DVD_W-2:0], fits};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* design/io_latency_stats_percentile.sv */
// Top level: I/O latency statistics with percentile selection over a sample memory.
`timescale 1ns / 1ps
// Record and clear words are taken in ST_IDLE. A query goes straight to ST_OUT when the
// class is invalid or empty or the denominator is 0; otherwise it forms the rank
// (multiply, then a 26-step divider), then makes 32 passes over the n stored samples of
// the class, one memory read per cycle. The radix select over the single sample memory
// read port sets the length of a query. No word is taken while a query is in progress;
// a record or clear word is taken while a result waits.
module io_latency_stats_percentile
  import iolsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [0:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_type,
  input  logic [CLS_W-1:0]  io_class,
  input  logic [LAT_W-1:0]  latency,
  input  logic [PCT_W-1:0]  pct_numerator,
  input  logic [PCT_W-1:0]  pct_denominator,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [LAT_W-1:0]  percentile_value,
  output logic [CNT_W-1:0]  event_total,
  output logic [MIN_W-1:0]  min_latency,
  output logic [LAT_W-1:0]  max_latency,
  output logic [SUM_W-1:0]  latency_sum,
  output logic [FILL_W-1:0] stored_samples
);
  logic record_enable;

  logic [FILL_W-1:0] fill     [NUM_CLASSES];
  logic [CNT_W-1:0]  ev_count [NUM_CLASSES];
  logic [MIN_W-1:0]  min_seen [NUM_CLASSES];
  logic [LAT_W-1:0]  max_seen [NUM_CLASSES];
  logic [SUM_W-1:0]  lat_total[NUM_CLASSES];

  logic [LAT_W-1:0] mem [MEM_DEPTH];
  logic [LAT_W-1:0] rd_data;
  logic             mem_we;
  logic [MEM_AW-1:0] mem_waddr;

  state_t state, state_next;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quot;

  logic             accept;
  logic             cls_ok;
  logic [FILL_W-1:0] fill_sel;
  logic             q_empty;
  logic [PCT_W-1:0] num_clamped;

  logic [CLS_W-1:0]  qcls;
  logic [FILL_W-1:0] n_q;
  logic [PCT_W-1:0]  num_q;
  logic [PCT_W-1:0]  den_q;
  logic [CNT_W-1:0]  s_cnt;
  logic [MIN_W-1:0]  s_min;
  logic [LAT_W-1:0]  s_max;
  logic [SUM_W-1:0]  s_sum;

  logic [FILL_W-1:0] rank;
  logic [FILL_W-1:0] idx;
  logic              rv;
  logic [FILL_W-1:0] cnt0;
  logic [BIT_W-1:0]  bit_idx;
  logic [LAT_W-1:0]  mask;
  logic [LAT_W-1:0]  prefix;
  logic              scan_done;
  logic              hit;
  logic              out_load;
  logic [IDX_W-1:0]  nm1;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RECORD_ENABLE) ? {31'd0, record_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RECORD_ENABLE) begin
      record_enable <= pwdata[0];
    end
  end

  assign accept      = req_valid && req_ready;
  assign cls_ok      = io_class < NUM_CLASSES_C;
  assign fill_sel    = cls_ok ? fill[io_class] : '0;
  assign q_empty     = !cls_ok || fill_sel == '0 || pct_denominator == '0;
  assign num_clamped = (pct_numerator > pct_denominator) ? pct_denominator : pct_numerator;

  assign mem_we    = accept && req_type == REQ_RECORD && record_enable && cls_ok &&
                     fill_sel < FILL_MAX;
  assign mem_waddr = {io_class, fill_sel[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= latency;
    end
    rd_data <= mem[{qcls, idx[IDX_W-1:0]}];
  end

  // per-class statistics
  always_ff @(posedge clk) begin
    if (rst || (accept && req_type == REQ_CLEAR)) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        fill[c]      <= '0;
        ev_count[c]  <= '0;
        min_seen[c]  <= '1;
        max_seen[c]  <= '0;
        lat_total[c] <= '0;
      end
    end else if (accept && req_type == REQ_RECORD && record_enable && cls_ok) begin
      if (ev_count[io_class] != COUNT_MAX) begin
        ev_count[io_class] <= ev_count[io_class] + 1'b1;
      end
      lat_total[io_class] <= lat_total[io_class] + SUM_W'(latency);
      if (MIN_W'(latency) < min_seen[io_class]) begin
        min_seen[io_class] <= MIN_W'(latency);
      end
      if (latency > max_seen[io_class]) begin
        max_seen[io_class] <= latency;
      end
      if (fill_sel < FILL_MAX) begin
        fill[io_class] <= fill_sel + 1'b1;
      end
    end
  end

  assign nm1 = IDX_W'(n_q - 1'b1);
  assign dvd = DVD_W'(nm1) * DVD_W'(num_q);

  iolsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (den_q),
    .done     (div_done),
    .quotient (quot)
  );

  assign scan_done = idx == n_q && !rv;
  assign hit       = rv && ((rd_data & mask) == prefix) && !rd_data[bit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && req_type == REQ_QUERY) begin
          state_next = q_empty ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done && bit_idx == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // query datapath: rank, then one radix-select pass per bit
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_QUERY) begin
      qcls   <= io_class;
      n_q    <= fill_sel;
      num_q  <= num_clamped;
      den_q  <= pct_denominator;
      prefix <= '0;
      s_cnt  <= cls_ok ? ev_count[io_class] : '0;
      s_min  <= cls_ok ? min_seen[io_class] : '1;
      s_max  <= cls_ok ? max_seen[io_class] : '0;
      s_sum  <= cls_ok ? lat_total[io_class] : '0;
    end
    if (state == ST_DIV && div_done) begin
      rank    <= quot[FILL_W-1:0];
      idx     <= '0;
      rv      <= 1'b0;
      cnt0    <= '0;
      bit_idx <= BIT_W'(LAT_W - 1);
      mask    <= '0;
    end
    if (state == ST_SCAN) begin
      if (idx != n_q) begin
        idx <= idx + 1'b1;
        rv  <= 1'b1;
      end else begin
        rv <= 1'b0;
      end
      if (hit) begin
        cnt0 <= cnt0 + 1'b1;
      end
      if (scan_done) begin
        if (rank >= cnt0) begin
          rank            <= rank - cnt0;
          prefix[bit_idx] <= 1'b1;
        end
        mask[bit_idx] <= 1'b1;
        bit_idx       <= bit_idx - 1'b1;
        idx           <= '0;
        cnt0          <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      percentile_value <= prefix;
      event_total      <= s_cnt;
      min_latency      <= s_min;
      max_latency      <= s_max;
      latency_sum      <= s_sum;
      stored_samples   <= n_q;
    end
  end
endmodule
